### sv/ibanchk_pkg.sv
// ----------------------------------------------------------------------------
// ibanchk_pkg
// Shared types and constants of the IBAN check-digit validator: controller
// states, command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ibanchk_pkg;

   // Digit count bounds of the accepted format (two letters, then digits)
   localparam int unsigned MIN_DIGITS = 16;
   localparam int unsigned MAX_DIGITS = 32;

   localparam int unsigned POS_W   = 6;
   localparam int unsigned MOD_W   = 7;
   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned VAL_W   = 11;   // r*10 + d <= 1269
   localparam int unsigned MSH_W   = 16;   // modulus << 9
   localparam int unsigned STEP_W  = 3;
   localparam int unsigned TAIL_W  = 3;

   // Register byte address of the modulus
   localparam logic [1:0] ADDR_MODULUS = 2'd0;

   localparam logic [POS_W-1:0]  POS_MAX     = '1;
   localparam logic [POS_W-1:0]  POS_LO      = POS_W'(MIN_DIGITS + 1);
   localparam logic [POS_W-1:0]  POS_HI      = POS_W'(MAX_DIGITS + 1);
   localparam logic [POS_W-1:0]  POS_MIN_LEN = POS_W'(3);
   localparam logic [POS_W-1:0]  POS_DIGITS  = POS_W'(4);
   localparam logic [STEP_W-1:0] STEP_LAST   = STEP_W'(4);
   localparam logic [TAIL_W-1:0] TAIL_COUNT  = TAIL_W'(6);

   localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'd57;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'd65;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'd90;
   localparam logic [CHAR_W-1:0] LETTER_BIAS = 8'd55;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_REDUCE = 5'b00010,
      ST_CHECK  = 5'b00100,
      ST_LOAD   = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   typedef struct packed {
      logic accept;     // take the transaction on the request channel
      logic load_tail;  // load the next rearranged tail digit into the fold
      logic step;       // one reduction iteration
      logic emit;       // write the result register and clear the IBAN state
   } cmd_type;

   typedef struct packed {
      logic fold_char;  // accepted character is a digit past the head
      logic last;       // accepted character ends the IBAN
      logic red_done;   // reduction finishes this cycle
      logic tail_done;  // all tail digits folded
      logic fmt_ok;     // format verdict of the current IBAN
      logic out_free;   // result register can take a new transaction
   } status_type;

endpackage

### sv/iban_check_digit_validator.sv
// ----------------------------------------------------------------------------
// iban_check_digit_validator
// IBAN format and mod-97 check-digit validator, one character per transaction.
// ----------------------------------------------------------------------------
// Feed the IBAN one ASCII character per request transaction and flag the final
// one with req_last_char; one result transaction follows each last character.
// The format must be two capitals A-Z then 16 to 32 decimal digits. Digits past
// the fourth character are folded into a running remainder as they arrive;
// at the end the country letters (code minus 55) and the check digits are
// folded in, and checksum_ok is set when the format holds and the remainder
// equals one. Each fold runs through a shift-subtract modulo unit that takes
// five iterations, and the request channel stalls while a fold is reduced. A
// last character adds a format check and, when the format holds, six tail
// folds; the request channel stays stalled until the result is emitted.
// The modulus register (byte address 0, reset 97) should be written only
// while no IBAN is in progress.
module iban_check_digit_validator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_last_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_format_ok,
   output logic        rsp_checksum_ok,
   output logic [6:0]  rsp_remainder,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam logic [6:0] MODULUS_RESET = 7'd97;

   logic [6:0]              modulus_ff;
   ibanchk_pkg::cmd_type    cmd;
   ibanchk_pkg::status_type status;

   // Configuration register
   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET;
      end else if (psel && penable && pwrite && (paddr == ibanchk_pkg::ADDR_MODULUS)) begin
         modulus_ff <= pwdata[6:0];
      end
   end

   assign prdata = (paddr == ibanchk_pkg::ADDR_MODULUS) ? {25'b0, modulus_ff} : 32'b0;

   ibanchk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ibanchk_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_char_code   (req_char_code),
      .req_last_char   (req_last_char),
      .modulus         (modulus_ff),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_format_ok   (rsp_format_ok),
      .rsp_checksum_ok (rsp_checksum_ok),
      .rsp_remainder   (rsp_remainder)
   );

endmodule

### sv/ibanchk_ctrl.sv
// ----------------------------------------------------------------------------
// ibanchk_ctrl
// Controller state machine: accepts characters, sequences the modulo
// reductions of the running remainder and the tail fold, and emits results.
// ----------------------------------------------------------------------------
module ibanchk_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  ibanchk_pkg::status_type status,
   output ibanchk_pkg::cmd_type    cmd
);

   ibanchk_pkg::state_type state_ff, state_in;
   logic                   last_ff, last_in;
   logic                   tail_ff, tail_in;

   assign req_stall = (state_ff != ibanchk_pkg::ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      last_in       = last_ff;
      tail_in       = tail_ff;
      cmd           = '0;
      unique case (state_ff)
         ibanchk_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               last_in    = status.last;
               if (status.fold_char) begin
                  state_in = ibanchk_pkg::ST_REDUCE;
               end else if (status.last) begin
                  state_in = ibanchk_pkg::ST_CHECK;
               end
            end
         end
         ibanchk_pkg::ST_REDUCE: begin
            cmd.step = 1'b1;
            if (status.red_done) begin
               priority if (tail_ff && status.tail_done) begin
                  state_in = ibanchk_pkg::ST_EMIT;
               end else if (tail_ff) begin
                  state_in = ibanchk_pkg::ST_LOAD;
               end else if (last_ff) begin
                  state_in = ibanchk_pkg::ST_CHECK;
               end else begin
                  state_in = ibanchk_pkg::ST_IDLE;
               end
            end
         end
         ibanchk_pkg::ST_CHECK: begin
            if (status.fmt_ok) begin
               state_in = ibanchk_pkg::ST_LOAD;
            end else begin
               state_in = ibanchk_pkg::ST_EMIT;
            end
         end
         ibanchk_pkg::ST_LOAD: begin
            cmd.load_tail = 1'b1;
            tail_in       = 1'b1;
            state_in      = ibanchk_pkg::ST_REDUCE;
         end
         ibanchk_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               tail_in  = 1'b0;
               last_in  = 1'b0;
               state_in = ibanchk_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ibanchk_pkg::ST_IDLE;
         end
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ibanchk_pkg::ST_IDLE;
         last_ff  <= 1'b0;
         tail_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
         tail_ff  <= tail_in;
      end
   end

endmodule

### sv/ibanchk_dp.sv
// ----------------------------------------------------------------------------
// ibanchk_dp
// Datapath: head characters, format tracking, running decimal remainder with
// an iterative shift-subtract modulo unit, and the result register.
// ----------------------------------------------------------------------------
module ibanchk_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              req_char_code,
   input  logic                    req_last_char,
   input  logic [6:0]              modulus,
   input  ibanchk_pkg::cmd_type    cmd,
   output ibanchk_pkg::status_type status,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_format_ok,
   output logic                    rsp_checksum_ok,
   output logic [6:0]              rsp_remainder
);

   localparam int unsigned PW = ibanchk_pkg::POS_W;
   localparam int unsigned VW = ibanchk_pkg::VAL_W;
   localparam int unsigned MW = ibanchk_pkg::MSH_W;

   logic [7:0]                       head_ff [4];
   logic [PW-1:0]                    pos_ff, pos_in;
   logic                             good_ff, good_in;
   logic                             fmt_ff;
   logic [6:0]                       rem_ff, rem_in;
   logic [VW-1:0]                    val_ff, val_in;
   logic [MW-1:0]                    msh_ff, msh_in;
   logic [ibanchk_pkg::STEP_W-1:0]   step_ff;
   logic [ibanchk_pkg::TAIL_W-1:0]   tail_ff;
   logic                             out_valid_ff;
   logic                             out_fmt_ff, out_sum_ff;
   logic [6:0]                       out_rem_ff;

   logic                             is_digit, is_upper, char_good;
   logic                             fmt_in;
   logic [3:0]                       load_digit, tail_digit;
   logic [7:0]                       letter;
   logic [7:0]                       letter_val;
   logic [3:0]                       letter_tens;
   logic [3:0]                       letter_units;
   logic [6:0]                       load_rem;
   logic [VW-1:0]                    sub1, sub2;
   logic [MW-1:0]                    msh_half;
   logic                             mod_small;

   // Classify the incoming character
   assign is_digit = (req_char_code >= ibanchk_pkg::CHAR_ZERO) &&
                     (req_char_code <= ibanchk_pkg::CHAR_NINE);
   assign is_upper = (req_char_code >= ibanchk_pkg::CHAR_UPPER_A) &&
                     (req_char_code <= ibanchk_pkg::CHAR_UPPER_Z);
   assign char_good = (pos_ff < PW'(2)) ? is_upper : is_digit;
   assign good_in   = good_ff && char_good;

   // Format verdict once the last character is in
   assign fmt_in = good_in && (pos_ff >= ibanchk_pkg::POS_MIN_LEN) &&
                   (pos_ff >= ibanchk_pkg::POS_LO) && (pos_ff <= ibanchk_pkg::POS_HI) &&
                   (pos_ff != ibanchk_pkg::POS_MAX);

   // Split a country letter into its two decimal digits (value 10 to 35)
   assign letter     = tail_ff[1] ? head_ff[1] : head_ff[0];
   assign letter_val = letter - ibanchk_pkg::LETTER_BIAS;
   always_comb begin
      priority if (letter_val >= 8'd30) begin
         letter_tens = 4'd3;
      end else if (letter_val >= 8'd20) begin
         letter_tens = 4'd2;
      end else begin
         letter_tens = 4'd1;
      end
   end
   assign letter_units = 4'(letter_val -
                            8'({letter_tens, 3'b000} + {2'b00, letter_tens, 1'b0}));

   // Pick the tail digit in rearranged order: letters, then check digits
   always_comb begin
      unique case (tail_ff)
         3'd0, 3'd2: tail_digit = letter_tens;
         3'd1, 3'd3: tail_digit = letter_units;
         3'd4:       tail_digit = head_ff[2][3:0];
         default:    tail_digit = head_ff[3][3:0];
      endcase
   end

   assign load_digit = cmd.load_tail ? tail_digit : req_char_code[3:0];
   assign load_rem   = rem_ff;

   // Two conditional subtractions of the shifted modulus per iteration
   assign msh_half = msh_ff >> 1;
   assign sub1 = ({{(MW-VW){1'b0}}, val_ff} >= msh_ff) ?
                 VW'({{(MW-VW){1'b0}}, val_ff} - msh_ff) : val_ff;
   assign sub2 = ({{(MW-VW){1'b0}}, sub1} >= msh_half) ?
                 VW'({{(MW-VW){1'b0}}, sub1} - msh_half) : sub1;
   assign mod_small = (modulus <= 7'd1);

   // Load a new fold: r*10 + d, modulus aligned to the top step
   always_comb begin
      val_in = val_ff;
      msh_in = msh_ff;
      if ((cmd.accept && status.fold_char) || cmd.load_tail) begin
         val_in = VW'({load_rem, 3'b000}) + VW'({load_rem, 1'b0}) + VW'(load_digit);
         msh_in = {modulus, 9'b0};
      end else if (cmd.step) begin
         val_in = sub2;
         msh_in = msh_ff >> 2;
      end
   end

   // Remainder update at the end of a reduction, clear after the result
   always_comb begin
      rem_in = rem_ff;
      if (cmd.emit) begin
         rem_in = '0;
      end else if (cmd.step && status.red_done) begin
         rem_in = mod_small ? 7'd0 : sub2[6:0];
      end
   end

   // Position and format tracking
   always_comb begin
      pos_in = pos_ff;
      if (cmd.emit) begin
         pos_in = '0;
      end else if (cmd.accept && !req_last_char && (pos_ff != ibanchk_pkg::POS_MAX)) begin
         pos_in = pos_ff + PW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         good_ff <= 1'b1;
         rem_ff  <= '0;
         step_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         rem_ff <= rem_in;
         if (cmd.emit) begin
            good_ff <= 1'b1;
         end else if (cmd.accept) begin
            good_ff <= good_in;
         end
         if (cmd.step) begin
            step_ff <= status.red_done ? '0 : step_ff + 3'd1;
         end
      end
   end

   // Fold operands, head characters, verdict and tail index
   always_ff @(posedge clock) begin
      val_ff <= val_in;
      msh_ff <= msh_in;
      if (cmd.accept) begin
         fmt_ff  <= fmt_in;
         tail_ff <= '0;
         if (pos_ff < ibanchk_pkg::POS_DIGITS) begin
            head_ff[pos_ff[1:0]] <= req_char_code;
         end
      end else if (cmd.load_tail) begin
         tail_ff <= tail_ff + 3'd1;
      end
   end

   // Result register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_fmt_ff <= fmt_ff;
         out_sum_ff <= fmt_ff && (rem_ff == 7'd1);
         out_rem_ff <= fmt_ff ? rem_ff : 7'd0;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_format_ok   = out_fmt_ff;
   assign rsp_checksum_ok = out_sum_ff;
   assign rsp_remainder   = out_rem_ff;

   // Status toward the controller
   assign status.fold_char = is_digit && (pos_ff >= ibanchk_pkg::POS_DIGITS);
   assign status.last      = req_last_char;
   assign status.red_done  = (step_ff == ibanchk_pkg::STEP_LAST);
   assign status.tail_done = (tail_ff == ibanchk_pkg::TAIL_COUNT);
   assign status.fmt_ok    = fmt_ff;
   assign status.out_free  = !out_valid_ff || !rsp_stall;

endmodule
